// File: src/rsi_pkg.sv
// Package: shared types, codes and constants of the RBF SVM scoring unit.
package rsi_pkg;

   // Operation codes carried on the request word
   typedef enum logic [1:0] {
      OP_SV_FEATURE = 2'd0,
      OP_COEF       = 2'd1,
      OP_QUERY      = 2'd2,
      OP_NONE       = 2'd3
   } op_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_GAMMA    = 2'd0,
      CSR_BIAS     = 2'd1,
      CSR_VECTORS  = 2'd2,
      CSR_FEATURES = 2'd3
   } csr_index_type;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // Token that travels with each support-vector row down the pipe
   typedef struct packed {
      logic valid;  // row takes part in the sum
      logic last;   // end-of-query marker
   } token_type;

   // Query feature write broadcast to the cells
   typedef struct packed {
      logic               write;
      logic [3:0]         index;
      logic signed [15:0] value;
   } qwrite_type;

   localparam logic [31:0] GAMMA_RESET    = 32'd65536;
   localparam logic [4:0]  FEATURES_RESET = 5'd1;
   localparam logic [16:0] LOG2E_Q16      = 17'd94548;
   localparam logic signed [63:0] SCORE_MAX = 64'sd140737488355327;
   localparam logic signed [63:0] SCORE_MIN = -64'sd140737488355328;

   // round(32768 * 2^(-k/32))
   localparam logic [15:0] EXP2_TAB [32] = '{
      16'd32768, 16'd32066, 16'd31379, 16'd30706, 16'd30048, 16'd29405, 16'd28774, 16'd28158,
      16'd27554, 16'd26964, 16'd26386, 16'd25821, 16'd25268, 16'd24726, 16'd24196, 16'd23678,
      16'd23170, 16'd22674, 16'd22188, 16'd21713, 16'd21248, 16'd20792, 16'd20347, 16'd19911,
      16'd19484, 16'd19066, 16'd18658, 16'd18258, 16'd17867, 16'd17484, 16'd17109, 16'd16743
   };

endpackage

// File: src/rsi_ifs.sv
// Interfaces: request and response channels of the scoring unit.
interface rsi_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [5:0]         vector_index;
   logic [3:0]         feature_index;
   logic signed [15:0] feature_value;
   logic [31:0]        multiplier;
   logic signed [1:0]  class_label;
   logic               last_feature;

   modport source (output valid, op, vector_index, feature_index, feature_value,
                   multiplier, class_label, last_feature, input ready);
   modport sink   (input valid, op, vector_index, feature_index, feature_value,
                   multiplier, class_label, last_feature, output ready);
endinterface

interface rsi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] score;
   logic               saturated;

   modport source (output valid, score, saturated, input ready);
   modport sink   (input valid, score, saturated, output ready);
endinterface

// File: src/rsi_dist_cell.sv
// Distance cell: holds one query feature and adds its squared difference to the passing sum.
module rsi_dist_cell #(
   parameter int MAX_FEATURES = 16,
   parameter int LANE         = 0,
   parameter int NFW          = 5,
   parameter int DIST_W       = 37
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rsi_pkg::qwrite_type          qwrite,
   input  logic [NFW-1:0]               features_used,
   input  rsi_pkg::token_type           tok_in,
   input  logic [MAX_FEATURES*16-1:0]   row_in,
   input  logic [DIST_W-1:0]            sum_in,
   output rsi_pkg::token_type           tok_out,
   output logic [MAX_FEATURES*16-1:0]   row_out,
   output logic [DIST_W-1:0]            sum_out
);
   import rsi_pkg::*;

   logic signed [15:0] query_ff;
   logic signed [15:0] sv_feat;
   logic signed [16:0] diff;
   logic signed [33:0] diff_sq;
   logic               lane_on;
   token_type          tok_ff;
   logic [MAX_FEATURES*16-1:0] row_ff;
   logic [DIST_W-1:0]  sum_ff;
   logic [DIST_W-1:0]  sum_in_w;

   // hold this lane's query feature
   always_ff @(posedge clock) begin
      if (qwrite.write && (32'(qwrite.index) == LANE)) begin
         query_ff <= qwrite.value;
      end
   end

   // square the difference for this lane
   always_comb begin
      sv_feat  = row_in[LANE*16 +: 16];
      diff     = 17'(sv_feat) - 17'(query_ff);
      diff_sq  = diff * diff;
      lane_on  = (LANE < 32'(features_used));
      sum_in_w = sum_in + (lane_on ? DIST_W'(diff_sq[31:0]) : '0);
   end

   // advance the word to the neighbor
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
      row_ff <= row_in;
      sum_ff <= sum_in_w;
   end

   assign tok_out = tok_ff;
   assign row_out = row_ff;
   assign sum_out = sum_ff;
endmodule

// File: src/rsi_kernel.sv
// Kernel pipe: gamma scaling, exp approximation, coefficient product and score accumulator.
module rsi_kernel #(
   parameter int MAX_VECTORS = 64,
   parameter int DIST_W      = 37,
   parameter int ACC_W       = 57
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [31:0]               gamma,
   input  logic signed [31:0]        bias,
   input  logic                      coef_we,
   input  logic [((MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1)-1:0] coef_addr,
   input  logic signed [33:0]        coef_data,
   input  rsi_pkg::token_type        tok_in,
   input  logic [DIST_W-1:0]         dist_in,
   output logic                      done,
   output logic signed [ACC_W-1:0]   acc
);
   import rsi_pkg::*;

   localparam int VW     = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
   localparam int LO_W   = (DIST_W + 1) / 2;
   localparam int HI_W   = DIST_W - LO_W;
   localparam int FULL_W = 32 + DIST_W + 1;

   logic signed [33:0] coef_mem [MAX_VECTORS];
   logic [VW-1:0]      cidx_ff, cidx_in;

   token_type          tok1_ff, tok2_ff, tok3_ff, tok4_ff, tok5_ff, tok6_ff;
   logic [31+LO_W:0]   plo1_ff, plo2_ff;
   logic [HI_W-1:0]    dhi1_ff;
   logic [31+HI_W:0]   phi2_ff;
   logic [FULL_W-1:0]  full;
   logic               big3_ff, big4_ff;
   logic [19:0]        t3_ff;
   logic [36:0]        u_w;
   logic [20:0]        u4_ff;
   logic [15:0]        kval;
   logic [15:0]        k5_ff;
   logic signed [33:0] coef4_ff, coef5_ff;
   logic signed [50:0] prod6_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic               done_ff;

   // store weighted coefficients
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_addr] <= coef_data;
      end
   end

   // split product of gamma and distance, then scale and test the range
   always_comb begin
      full = (FULL_W'(phi2_ff) << LO_W) + FULL_W'(plo2_ff);
      u_w  = 37'(t3_ff) * 37'(LOG2E_Q16);
   end

   // table lookup and shift give exp(-t) in Q1.15
   always_comb begin
      if (big4_ff || u4_ff[20]) begin
         kval = '0;
      end else begin
         kval = EXP2_TAB[u4_ff[15:11]] >> u4_ff[19:16];
      end
   end

   // step the coefficient read address with each live row
   always_comb begin
      cidx_in = cidx_ff;
      if (start) begin
         cidx_in = '0;
      end else if (tok3_ff.valid) begin
         cidx_in = cidx_ff + VW'(1);
      end
   end

   // accumulate the weighted kernel values
   always_comb begin
      acc_in = acc_ff;
      if (start) begin
         acc_in = ACC_W'(bias) <<< 15;
      end else if (tok6_ff.valid) begin
         acc_in = acc_ff + ACC_W'(prod6_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok1_ff <= '0;
         tok2_ff <= '0;
         tok3_ff <= '0;
         tok4_ff <= '0;
         tok5_ff <= '0;
         tok6_ff <= '0;
         cidx_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         tok1_ff <= tok_in;
         tok2_ff <= tok1_ff;
         tok3_ff <= tok2_ff;
         tok4_ff <= tok3_ff;
         tok5_ff <= tok4_ff;
         tok6_ff <= tok5_ff;
         cidx_ff <= cidx_in;
         done_ff <= tok6_ff.last;
      end
      plo1_ff  <= (32+LO_W)'(gamma) * (32+LO_W)'(dist_in[LO_W-1:0]);
      dhi1_ff  <= dist_in[DIST_W-1:LO_W];
      phi2_ff  <= (32+HI_W)'(gamma) * (32+HI_W)'(dhi1_ff);
      plo2_ff  <= plo1_ff;
      big3_ff  <= |full[FULL_W-1:36];
      t3_ff    <= full[35:16];
      u4_ff    <= u_w[36:16];
      big4_ff  <= big3_ff;
      coef4_ff <= coef_mem[cidx_ff];
      k5_ff    <= kval;
      coef5_ff <= coef4_ff;
      prod6_ff <= 51'(coef5_ff) * 51'(signed'({1'b0, k5_ff}));
      acc_ff   <= acc_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;
endmodule

// File: src/rbf_svm_inference_unit.sv
// Top level: RBF-kernel SVM scoring unit with model storage and a chain of distance cells.
//
//   channel | dir | handshake        | contents
//   req_bus | in  | valid/ready      | op, indexes, feature, multiplier, label, last flag
//   rsp_bus | out | valid/ready      | score (Q32.16, 48 bit), saturated
//   csr_*   | in  | write enable     | gamma, bias, vectors in use, features in use
//
// A scoring item walks the N vectors in use:
// one support-vector row is read per cycle from the row memory
// and passes down the cell chain and the kernel pipe.
// Reset is synchronous; it clears control and registers, not the model memories.
// A waiting result does not block loads; a new score starts only after the prior finished.
module rbf_svm_inference_unit #(
   parameter int MAX_VECTORS  = 64,
   parameter int MAX_FEATURES = 16
) (
   input  logic         clock,
   input  logic         reset,
   rsi_req_if.sink      req_bus,
   rsi_rsp_if.source    rsp_bus,
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_write_data
);
   import rsi_pkg::*;

   localparam int VW     = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
   localparam int FW     = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int VXW    = (VW > 6) ? VW : 6;
   localparam int FXW    = (FW > 4) ? FW : 4;
   localparam int CW     = $clog2(MAX_VECTORS + 1);
   localparam int NFW    = $clog2(MAX_FEATURES + 1);
   localparam int DIST_W = 32 + NFW;
   localparam int ACC_W  = 50 + CW;
   localparam int QW     = ACC_W - 15;

   // configuration registers
   logic [31:0]        gamma_ff;
   logic signed [31:0] bias_ff;
   logic [6:0]         vectors_ff;
   logic [4:0]         features_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff    <= GAMMA_RESET;
         bias_ff     <= '0;
         vectors_ff  <= '0;
         features_ff <= FEATURES_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAMMA:    gamma_ff    <= csr_write_data;
            CSR_BIAS:     bias_ff     <= csr_write_data;
            CSR_VECTORS:  vectors_ff  <= csr_write_data[6:0];
            CSR_FEATURES: features_ff <= csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   // clamp the counts
   logic [CW-1:0]  nv;
   logic [NFW-1:0] nf;
   always_comb begin
      nv = (32'(vectors_ff) > MAX_VECTORS) ? CW'(MAX_VECTORS) : CW'(vectors_ff);
      nf = (32'(features_ff) > MAX_FEATURES) ? NFW'(MAX_FEATURES) : NFW'(features_ff);
   end

   // decode the request word
   state_type       state_ff, state_in;
   logic            accept;
   op_type          op;
   logic [VXW-1:0]  vi_x;
   logic [FXW-1:0]  fi_x;
   logic            vi_ok, fi_ok;
   logic [VW-1:0]   va;
   logic [FW-1:0]   fa;
   logic signed [33:0] coef;
   logic            score_go;

   always_comb begin
      accept = req_bus.valid && req_bus.ready;
      op     = op_type'(req_bus.op);
      vi_x   = VXW'(req_bus.vector_index);
      fi_x   = FXW'(req_bus.feature_index);
      va     = vi_x[VW-1:0];
      fa     = fi_x[FW-1:0];
      vi_ok  = 32'(req_bus.vector_index) < MAX_VECTORS;
      fi_ok  = 32'(req_bus.feature_index) < MAX_FEATURES;
      unique case (req_bus.class_label)
         2'sb01:         coef = signed'({2'b00, req_bus.multiplier});
         2'sb11, 2'sb10: coef = 34'sd0 - signed'({2'b00, req_bus.multiplier});
         default:        coef = '0;
      endcase
      score_go = accept && (op == OP_QUERY) && req_bus.last_feature;
   end

   assign req_bus.ready = (state_ff == ST_IDLE);

   // support-vector row memory, one lane written per load
   logic [MAX_FEATURES-1:0][15:0] sv_mem [MAX_VECTORS];
   logic [MAX_FEATURES*16-1:0]    row_ff;
   logic [CW-1:0]                 vcnt_ff, vcnt_in;
   token_type                     tok0_ff, tok0_in;

   always_ff @(posedge clock) begin
      if (accept && (op == OP_SV_FEATURE) && vi_ok && fi_ok) begin
         sv_mem[va][fa] <= req_bus.feature_value;
      end
      row_ff <= sv_mem[vcnt_ff[VW-1:0]];
   end

   qwrite_type qwrite;
   always_comb begin
      qwrite.write = accept && (op == OP_QUERY) && fi_ok;
      qwrite.index = req_bus.feature_index;
      qwrite.value = req_bus.feature_value;
   end

   // cell chain
   token_type                  tok_w [MAX_FEATURES+1];
   logic [MAX_FEATURES*16-1:0] row_w [MAX_FEATURES+1];
   logic [DIST_W-1:0]          sum_w [MAX_FEATURES+1];

   assign tok_w[0] = tok0_ff;
   assign row_w[0] = row_ff;
   assign sum_w[0] = '0;

   for (genvar g = 0; g < MAX_FEATURES; g++) begin : g_cell
      rsi_dist_cell #(
         .MAX_FEATURES (MAX_FEATURES),
         .LANE         (g),
         .NFW          (NFW),
         .DIST_W       (DIST_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .qwrite        (qwrite),
         .features_used (nf),
         .tok_in        (tok_w[g]),
         .row_in        (row_w[g]),
         .sum_in        (sum_w[g]),
         .tok_out       (tok_w[g+1]),
         .row_out       (row_w[g+1]),
         .sum_out       (sum_w[g+1])
      );
   end

   // kernel and accumulator
   logic                    kdone;
   logic signed [ACC_W-1:0] acc;

   rsi_kernel #(
      .MAX_VECTORS (MAX_VECTORS),
      .DIST_W      (DIST_W),
      .ACC_W       (ACC_W)
   ) u_kernel (
      .clock     (clock),
      .reset     (reset),
      .start     (score_go),
      .gamma     (gamma_ff),
      .bias      (bias_ff),
      .coef_we   (accept && (op == OP_COEF) && vi_ok),
      .coef_addr (va),
      .coef_data (coef),
      .tok_in    (tok_w[MAX_FEATURES]),
      .dist_in   (sum_w[MAX_FEATURES]),
      .done      (kdone),
      .acc       (acc)
   );

   // round half up, shift to Q32.16 and clip
   logic signed [ACC_W-1:0] rnd;
   logic signed [QW-1:0]    q;
   logic signed [63:0]      q64;
   logic                    hi_clip, lo_clip;
   always_comb begin
      rnd     = acc + ACC_W'(16384);
      q       = rnd[ACC_W-1:15];
      q64     = 64'(q);
      hi_clip = q64 > SCORE_MAX;
      lo_clip = q64 < SCORE_MIN;
   end

   // sequencer
   logic               rsp_valid_ff;
   logic signed [47:0] score_ff;
   logic               sat_ff;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in = state_ff;
      vcnt_in  = vcnt_ff;
      tok0_in  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            vcnt_in = '0;
            if (score_go) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            tok0_in.valid = (vcnt_ff < nv);
            tok0_in.last  = (vcnt_ff == nv);
            vcnt_in       = vcnt_ff + CW'(1);
            if (vcnt_ff == nv) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (kdone) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcnt_ff      <= '0;
         tok0_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vcnt_ff  <= vcnt_in;
         tok0_ff  <= tok0_in;
         if ((state_ff == ST_FINISH) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      // load the result word
      if ((state_ff == ST_FINISH) && slot_free) begin
         score_ff <= hi_clip ? SCORE_MAX[47:0] : (lo_clip ? SCORE_MIN[47:0] : q64[47:0]);
         sat_ff   <= hi_clip || lo_clip;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.score     = score_ff;
   assign rsp_bus.saturated = sat_ff;
endmodule

// File: src/rsi_checker.sv
// Checker: port-level properties of the scoring unit, bound to the top level.
module rsi_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_op,
   input logic               req_last,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [47:0] rsp_score,
   input logic               rsp_saturated
);
   import rsi_pkg::*;

   // a waiting result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled score holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_score))
      else $error("score changed while stalled");

   // a clipped score sits at a range limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_score == SCORE_MAX[47:0]) || (rsp_score == SCORE_MIN[47:0]))
      else $error("saturated flag without a limit score");

   // a scoring word closes the request side
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_QUERY) && req_last |=> !req_ready)
      else $error("request taken during scoring");

   // reset empties the result side
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind rbf_svm_inference_unit rsi_checker u_rsi_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_op        (req_bus.op),
   .req_last      (req_bus.last_feature),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_score     (rsp_bus.score),
   .rsp_saturated (rsp_bus.saturated)
);
